// ===== sv/prpi_pkg.sv =====
// shared types, constants and state codes of the pagerank power iteration block
package prpi_pkg;

    localparam int MAX_PAGES_DEF  = 64;
    localparam int COUNT_BITS_DEF = 8;

    localparam int PAGE_W     = 6;
    localparam int RANK_W     = 32;
    localparam int NEXT_W     = 40;
    localparam int DAMP_W     = 16;
    localparam int ITER_W     = 10;
    localparam int TOL_W      = 32;
    localparam int PC_W       = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // shared divider widths: widest dividend is next << 31, widest divisor is the total
    localparam int DIV_W = 72;
    localparam int DEN_W = 48;

    localparam logic [RANK_W-1:0] ONE_Q31 = 32'h8000_0000;

    localparam logic [PC_W-1:0]   PAGE_COUNT_RST = 7'd64;
    localparam logic [DAMP_W-1:0] DAMPING_RST    = 16'd55706;
    localparam logic [TOL_W-1:0]  TOLERANCE_RST  = 32'd2147;
    localparam logic [ITER_W-1:0] MAX_ITER_RST   = 10'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAGE_COUNT = 2'd0,
        CFG_DAMPING    = 2'd1,
        CFG_TOLERANCE  = 2'd2,
        CFG_MAX_ITER   = 2'd3
    } cfg_index_t;

    typedef enum logic {
        CMD_LINK = 1'b0,
        CMD_RUN  = 1'b1
    } cmd_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_UNI,
        ST_UNI_WAIT,
        ST_INIT,
        ST_LOOP,
        ST_SUM,
        ST_TELE_LO,
        ST_TELE_HI,
        ST_TELE_DIV,
        ST_TELE_WAIT,
        ST_ROW,
        ST_ROW_MUL,
        ST_ROW_ADD,
        ST_SC_RD,
        ST_SC_LATCH,
        ST_SC_WAIT,
        ST_SC_ACC,
        ST_CHECK,
        ST_EM_RD,
        ST_EM_LATCH,
        ST_EM_WAIT,
        ST_EM_OUT
    } state_t;

    typedef struct packed {
        logic              valid;
        logic [PAGE_W-1:0] source;
        logic [PAGE_W-1:0] target;
    } link_req_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== sv/prpi_if.sv =====
// request and result channel interfaces
interface prpi_req_if
    import prpi_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic              command;
    logic [PAGE_W-1:0] source_page;
    logic [PAGE_W-1:0] target_page;

    modport source (output valid, command, source_page, target_page, input ready);
    modport sink (input valid, command, source_page, target_page, output ready);
endinterface

interface prpi_rsp_if
    import prpi_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [PAGE_W-1:0] page_index;
    logic [RANK_W-1:0] rank_value;
    logic [ITER_W-1:0] iterations_done;
    logic              converged;
    logic              last;

    modport source (output valid, page_index, rank_value, iterations_done, converged, last,
                    input ready);
    modport sink (input valid, page_index, rank_value, iterations_done, converged, last,
                  output ready);
endinterface

// ===== sv/prpi_div.sv =====
// shared restoring divider, one quotient bit per cycle
module prpi_div
    import prpi_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t div_req,
    output div_rsp_t div_rsp
);

    localparam int CNT_W = $clog2(DIV_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_W - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0] q_reg;
    logic [DEN_W:0]   rem_reg;
    logic [DEN_W-1:0] den_reg;

    logic [DEN_W:0]   rem_shift;
    logic [DEN_W:0]   rem_next;
    logic [DIV_W-1:0] q_next;

    always_comb
    begin
        rem_shift = {rem_reg[DEN_W-1:0], q_reg[DIV_W-1]};
        if (rem_shift >= {1'b0, den_reg})
        begin
            rem_next = rem_shift - {1'b0, den_reg};
            q_next   = {q_reg[DIV_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = rem_shift;
            q_next   = {q_reg[DIV_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == LAST_STEP);
            if (div_req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_req.start)
        begin
            q_reg   <= div_req.dividend;
            rem_reg <= '0;
            den_reg <= div_req.divisor;
        end
        else if (busy_reg)
        begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
        end
    end

    assign div_rsp.done     = done_reg;
    assign div_rsp.quotient = q_reg;

endmodule

// ===== sv/prpi_link_store.sv =====
// link count memory with saturating read-modify-write, forwarding and clearing pass
module prpi_link_store
    import prpi_pkg::*;
#(
    parameter int MAX_PAGES  = MAX_PAGES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    localparam int PB        = $clog2(MAX_PAGES),
    localparam int AW        = 2 * PB
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  link_req_t             link_req,
    input  logic [AW-1:0]         rd_addr,
    output logic [COUNT_BITS-1:0] rd_data,
    output logic                  busy
);

    localparam int DEPTH = MAX_PAGES * MAX_PAGES;

    logic [COUNT_BITS-1:0] mem [DEPTH];

    logic                  clr_busy_reg;
    logic [AW-1:0]         clr_idx_reg;
    logic                  lk_valid_reg;
    logic [AW-1:0]         lk_addr_reg;
    logic                  fw_valid_reg;
    logic [AW-1:0]         fw_addr_reg;
    logic [COUNT_BITS-1:0] fw_data_reg;
    logic [COUNT_BITS-1:0] rd_data_reg;

    logic                  link_hit;
    logic [AW-1:0]         link_addr;
    logic [AW-1:0]         mem_raddr;
    logic [COUNT_BITS-1:0] cnt_old;
    logic [COUNT_BITS-1:0] cnt_new;

    assign link_hit = link_req.valid
                   && ({1'b0, link_req.source} < (PAGE_W + 1)'(MAX_PAGES))
                   && ({1'b0, link_req.target} < (PAGE_W + 1)'(MAX_PAGES));
    assign link_addr = {link_req.target[PB-1:0], link_req.source[PB-1:0]};
    assign mem_raddr = link_hit ? link_addr : rd_addr;

    // the write of the previous link is not yet visible in the read data
    assign cnt_old = (fw_valid_reg && (fw_addr_reg == lk_addr_reg)) ? fw_data_reg : rd_data_reg;
    assign cnt_new = (&cnt_old) ? cnt_old : cnt_old + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
            lk_valid_reg <= 1'b0;
            fw_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (&clr_idx_reg)
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            lk_valid_reg <= link_hit;
            fw_valid_reg <= lk_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        lk_addr_reg <= link_addr;
        fw_addr_reg <= lk_addr_reg;
        fw_data_reg <= cnt_new;
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_idx_reg] <= '0;
        end
        else if (lk_valid_reg)
        begin
            mem[lk_addr_reg] <= cnt_new;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_busy_reg;

endmodule

// ===== sv/pagerank_power_iteration_top.sv =====
// pagerank power iteration over a counted link matrix, fixed point
//
//  channel   direction  handshake        payload
//  req       in         valid / ready    command, source_page, target_page
//  rsp       out        valid / ready    page_index, rank_value, iterations_done,
//                                        converged, last
//  cfg       in         cfg_we           cfg_index, cfg_data
//
// link items: one per cycle while req.ready is high, counted through a memory
// read-modify-write with forwarding; run item: each iteration walks the matrix and
// scales each page through the shared divider, the emit pass scales each page again,
// so the divider and the matrix memory port set the time
// after reset the link memory is cleared and req.ready stays low until it is done
// a stalled rsp holds its output register; the next page waits for it to drain
module pagerank_power_iteration_top
    import prpi_pkg::*;
#(
    parameter int MAX_PAGES  = MAX_PAGES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    prpi_req_if.sink              req,
    prpi_rsp_if.source            rsp
);

    localparam int PB      = $clog2(MAX_PAGES);
    localparam int NW      = PB + 1;
    localparam int PROD_W  = COUNT_BITS + RANK_W;
    localparam int CACC_W  = PROD_W + PB;
    localparam int S_W     = RANK_W + PB;
    localparam int A_W     = 17;
    localparam int PLO_W   = A_W + 19;
    localparam int PHI_W   = A_W + S_W - 19;
    localparam int P_W     = A_W + S_W;
    localparam int TELE_W  = P_W - 16;
    localparam int VS_W    = ((CACC_W > TELE_W) ? CACC_W : TELE_W) + 2;
    localparam int TOT_W   = NEXT_W + PB;
    localparam int DIST_W  = RANK_W + PB;

    // configuration
    logic [PC_W-1:0]   page_count_reg;
    logic [DAMP_W-1:0] damping_reg;
    logic [TOL_W-1:0]  tolerance_reg;
    logic [ITER_W-1:0] max_iter_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_count_reg <= PAGE_COUNT_RST;
            damping_reg    <= DAMPING_RST;
            tolerance_reg  <= TOLERANCE_RST;
            max_iter_reg   <= MAX_ITER_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PAGE_COUNT: page_count_reg <= cfg_data[PC_W-1:0];
                CFG_DAMPING:    damping_reg    <= cfg_data[DAMP_W-1:0];
                CFG_TOLERANCE:  tolerance_reg  <= cfg_data[TOL_W-1:0];
                CFG_MAX_ITER:   max_iter_reg   <= cfg_data[ITER_W-1:0];
            endcase
        end
    end

    // control and datapath registers
    state_t              state_reg, state_next;
    logic [NW-1:0]       idx_reg, idx_next;
    logic [NW-1:0]       row_reg, row_next;
    logic [NW-1:0]       n_reg, n_next;
    logic                bank_reg, bank_next;
    logic                final_reg, final_next;
    logic                conv_reg, conv_next;
    logic [ITER_W-1:0]   done_reg, done_next;
    logic                p1_reg, p1_next;
    logic                p2_reg, p2_next;
    logic                out_valid_reg, out_valid_next;

    logic [RANK_W-1:0]   uni_reg, uni_next;
    logic [S_W-1:0]      s_acc_reg, s_acc_next;
    logic [PLO_W-1:0]    pa_reg, pa_next;
    logic [PHI_W-1:0]    pb_reg, pb_next;
    logic [TELE_W-1:0]   tele_reg, tele_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [CACC_W-1:0]   c_acc_reg, c_acc_next;
    logic [CACC_W-1:0]   mh_reg, mh_next;
    logic [31:0]         ml_reg, ml_next;
    logic [TOT_W-1:0]    total_reg, total_next;
    logic [RANK_W-1:0]   old_reg, old_next;
    logic [RANK_W-1:0]   fresh_reg, fresh_next;
    logic [DIST_W-1:0]   dist_reg, dist_next;
    logic [PAGE_W-1:0]   out_page_reg, out_page_next;
    logic [RANK_W-1:0]   out_rank_reg, out_rank_next;
    logic [ITER_W-1:0]   out_iter_reg, out_iter_next;
    logic                out_conv_reg, out_conv_next;
    logic                out_last_reg, out_last_next;

    // memories
    logic [RANK_W-1:0]   rank_mem [2 * MAX_PAGES];
    logic [NEXT_W-1:0]   next_mem [MAX_PAGES];
    logic [RANK_W-1:0]   rank_rd_reg;
    logic [NEXT_W-1:0]   next_rd_reg;
    logic [PB:0]         rank_raddr;
    logic [PB:0]         rank_waddr;
    logic                rank_we;
    logic [RANK_W-1:0]   rank_wdata;
    logic [PB-1:0]       next_raddr;
    logic                next_we;

    // helpers
    link_req_t           link_req;
    logic [2*PB-1:0]     cnt_raddr;
    logic [COUNT_BITS-1:0] cnt_rd;
    logic                clr_busy;
    div_req_t            div_req;
    div_rsp_t            div_rsp;
    logic                req_xfer;
    logic [NW-1:0]       n_eff;
    logic [NW-1:0]       last_idx;
    logic [A_W-1:0]      one_minus_d;
    logic [VS_W-1:0]     v_sum;
    logic [NEXT_W-1:0]   v_sat;
    logic [RANK_W-1:0]   abs_diff;
    logic                out_free;

    prpi_link_store #(
        .MAX_PAGES  (MAX_PAGES),
        .COUNT_BITS (COUNT_BITS)
    ) u_link_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .link_req (link_req),
        .rd_addr  (cnt_raddr),
        .rd_data  (cnt_rd),
        .busy     (clr_busy)
    );

    prpi_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

    assign req.ready = (state_reg == ST_IDLE) && !clr_busy;
    assign req_xfer  = req.valid && req.ready;

    assign link_req.valid  = req_xfer && (req.command == CMD_LINK);
    assign link_req.source = req.source_page;
    assign link_req.target = req.target_page;
    assign cnt_raddr       = {row_reg[PB-1:0], idx_reg[PB-1:0]};

    // page count of zero acts as one, above the array size as the array size
    assign n_eff = (page_count_reg == '0) ? NW'(1) :
                   (page_count_reg > PC_W'(MAX_PAGES)) ? NW'(MAX_PAGES) :
                   NW'(page_count_reg);
    assign last_idx    = n_reg - 1'b1;
    assign one_minus_d = 17'h10000 - {1'b0, damping_reg};

    // floor(c*d/2^16) split in a high and a low partial product, plus the teleport term
    assign v_sum = VS_W'(mh_reg) + VS_W'(ml_reg[31:16]) + VS_W'(tele_reg);
    assign v_sat = (|v_sum[VS_W-1:NEXT_W]) ? '1 : v_sum[NEXT_W-1:0];

    assign abs_diff = (fresh_reg >= old_reg) ? fresh_reg - old_reg : old_reg - fresh_reg;
    assign out_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        row_next       = row_reg;
        n_next         = n_reg;
        bank_next      = bank_reg;
        final_next     = final_reg;
        conv_next      = conv_reg;
        done_next      = done_reg;
        p1_next        = 1'b0;
        p2_next        = p1_reg;
        uni_next       = uni_reg;
        s_acc_next     = s_acc_reg;
        pa_next        = pa_reg;
        pb_next        = pb_reg;
        tele_next      = tele_reg;
        prod_next      = prod_reg;
        c_acc_next     = c_acc_reg;
        mh_next        = mh_reg;
        ml_next        = ml_reg;
        total_next     = total_reg;
        old_next       = old_reg;
        fresh_next     = fresh_reg;
        dist_next      = dist_reg;
        out_valid_next = rsp.ready ? 1'b0 : out_valid_reg;
        out_page_next  = out_page_reg;
        out_rank_next  = out_rank_reg;
        out_iter_next  = out_iter_reg;
        out_conv_next  = out_conv_reg;
        out_last_next  = out_last_reg;

        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = DEN_W'(n_reg);

        rank_raddr = {bank_reg, idx_reg[PB-1:0]};
        rank_waddr = {bank_reg, idx_reg[PB-1:0]};
        rank_we    = 1'b0;
        rank_wdata = uni_reg;
        next_raddr = row_reg[PB-1:0];
        next_we    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer && (req.command == CMD_RUN))
                begin
                    n_next     = n_eff;
                    bank_next  = 1'b0;
                    done_next  = '0;
                    conv_next  = 1'b0;
                    state_next = ST_UNI;
                end
            end

            ST_UNI:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(ONE_Q31);
                state_next       = ST_UNI_WAIT;
            end

            ST_UNI_WAIT:
            begin
                if (div_rsp.done)
                begin
                    uni_next   = div_rsp.quotient[RANK_W-1:0];
                    idx_next   = '0;
                    state_next = ST_INIT;
                end
            end

            ST_INIT:
            begin
                rank_we  = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == last_idx)
                begin
                    state_next = ST_LOOP;
                end
            end

            ST_LOOP:
            begin
                idx_next   = '0;
                s_acc_next = '0;
                if (done_reg < max_iter_reg)
                begin
                    done_next  = done_reg + 1'b1;
                    final_next = 1'b0;
                end
                else
                begin
                    final_next = 1'b1;
                end
                state_next = ST_SUM;
            end

            // rank sum, one read a cycle
            ST_SUM:
            begin
                if (idx_reg < n_reg)
                begin
                    p1_next  = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
                if (p1_reg)
                begin
                    s_acc_next = s_acc_reg + S_W'(rank_rd_reg);
                end
                else if (idx_reg == n_reg)
                begin
                    row_next   = '0;
                    state_next = final_reg ? ST_EM_RD : ST_TELE_LO;
                end
            end

            ST_TELE_LO:
            begin
                pa_next    = PLO_W'(one_minus_d) * PLO_W'(s_acc_reg[18:0]);
                state_next = ST_TELE_HI;
            end

            ST_TELE_HI:
            begin
                pb_next    = PHI_W'(one_minus_d) * PHI_W'(s_acc_reg[S_W-1:19]);
                state_next = ST_TELE_DIV;
            end

            ST_TELE_DIV:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'({pb_reg, 19'b0} + P_W'(pa_reg));
                state_next       = ST_TELE_WAIT;
            end

            ST_TELE_WAIT:
            begin
                if (div_rsp.done)
                begin
                    tele_next  = div_rsp.quotient[P_W-1:16];
                    row_next   = '0;
                    idx_next   = '0;
                    c_acc_next = '0;
                    total_next = '0;
                    state_next = ST_ROW;
                end
            end

            // one matrix row against the rank vector
            ST_ROW:
            begin
                if (idx_reg < n_reg)
                begin
                    p1_next  = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
                if (p1_reg)
                begin
                    prod_next = PROD_W'(cnt_rd) * PROD_W'(rank_rd_reg);
                end
                if (p2_reg)
                begin
                    c_acc_next = c_acc_reg + CACC_W'(prod_reg);
                end
                if ((idx_reg == n_reg) && !p1_reg && !p2_reg)
                begin
                    state_next = ST_ROW_MUL;
                end
            end

            ST_ROW_MUL:
            begin
                mh_next    = CACC_W'(c_acc_reg[CACC_W-1:16]) * CACC_W'(damping_reg);
                ml_next    = 32'(c_acc_reg[15:0]) * 32'(damping_reg);
                state_next = ST_ROW_ADD;
            end

            ST_ROW_ADD:
            begin
                next_we    = 1'b1;
                total_next = total_reg + TOT_W'(v_sat);
                c_acc_next = '0;
                idx_next   = '0;
                if (row_reg == last_idx)
                begin
                    row_next   = '0;
                    dist_next  = '0;
                    state_next = ST_SC_RD;
                end
                else
                begin
                    row_next   = row_reg + 1'b1;
                    state_next = ST_ROW;
                end
            end

            ST_SC_RD:
            begin
                rank_raddr = {bank_reg, row_reg[PB-1:0]};
                state_next = ST_SC_LATCH;
            end

            ST_SC_LATCH:
            begin
                old_next = rank_rd_reg;
                if (total_reg == '0)
                begin
                    fresh_next = uni_reg;
                    state_next = ST_SC_ACC;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_W'({next_rd_reg, 31'b0});
                    div_req.divisor  = DEN_W'(total_reg);
                    state_next       = ST_SC_WAIT;
                end
            end

            ST_SC_WAIT:
            begin
                if (div_rsp.done)
                begin
                    fresh_next = div_rsp.quotient[RANK_W-1:0];
                    state_next = ST_SC_ACC;
                end
            end

            // new vector goes to the other bank
            ST_SC_ACC:
            begin
                rank_we    = 1'b1;
                rank_waddr = {~bank_reg, row_reg[PB-1:0]};
                rank_wdata = fresh_reg;
                dist_next  = dist_reg + DIST_W'(abs_diff);
                if (row_reg == last_idx)
                begin
                    state_next = ST_CHECK;
                end
                else
                begin
                    row_next   = row_reg + 1'b1;
                    state_next = ST_SC_RD;
                end
            end

            ST_CHECK:
            begin
                if (dist_reg < DIST_W'(tolerance_reg))
                begin
                    conv_next  = 1'b1;
                    final_next = 1'b1;
                    idx_next   = '0;
                    s_acc_next = '0;
                    state_next = ST_SUM;
                end
                else
                begin
                    bank_next  = ~bank_reg;
                    state_next = ST_LOOP;
                end
            end

            ST_EM_RD:
            begin
                rank_raddr = {bank_reg, row_reg[PB-1:0]};
                state_next = ST_EM_LATCH;
            end

            ST_EM_LATCH:
            begin
                if (s_acc_reg == '0)
                begin
                    fresh_next = rank_rd_reg;
                    state_next = ST_EM_OUT;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_W'({rank_rd_reg, 31'b0});
                    div_req.divisor  = DEN_W'(s_acc_reg);
                    state_next       = ST_EM_WAIT;
                end
            end

            ST_EM_WAIT:
            begin
                if (div_rsp.done)
                begin
                    fresh_next = div_rsp.quotient[RANK_W-1:0];
                    state_next = ST_EM_OUT;
                end
            end

            ST_EM_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_page_next  = PAGE_W'(row_reg);
                    out_rank_next  = fresh_reg;
                    out_iter_next  = done_reg;
                    out_conv_next  = conv_reg;
                    out_last_next  = (row_reg == last_idx);
                    if (row_reg == last_idx)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        row_next   = row_reg + 1'b1;
                        state_next = ST_EM_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            p1_reg        <= 1'b0;
            p2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            p1_reg        <= p1_next;
            p2_reg        <= p2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        row_reg      <= row_next;
        n_reg        <= n_next;
        bank_reg     <= bank_next;
        final_reg    <= final_next;
        conv_reg     <= conv_next;
        done_reg     <= done_next;
        uni_reg      <= uni_next;
        s_acc_reg    <= s_acc_next;
        pa_reg       <= pa_next;
        pb_reg       <= pb_next;
        tele_reg     <= tele_next;
        prod_reg     <= prod_next;
        c_acc_reg    <= c_acc_next;
        mh_reg       <= mh_next;
        ml_reg       <= ml_next;
        total_reg    <= total_next;
        old_reg      <= old_next;
        fresh_reg    <= fresh_next;
        dist_reg     <= dist_next;
        out_page_reg <= out_page_next;
        out_rank_reg <= out_rank_next;
        out_iter_reg <= out_iter_next;
        out_conv_reg <= out_conv_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (rank_we)
        begin
            rank_mem[rank_waddr] <= rank_wdata;
        end
        rank_rd_reg <= rank_mem[rank_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_mem[row_reg[PB-1:0]] <= v_sat;
        end
        next_rd_reg <= next_mem[next_raddr];
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.page_index      = out_page_reg;
    assign rsp.rank_value      = out_rank_reg;
    assign rsp.iterations_done = out_iter_reg;
    assign rsp.converged       = out_conv_reg;
    assign rsp.last            = out_last_reg;

endmodule

// ===== sv/prpi_checker.sv =====
// port-level checks of the pagerank block and their binding
module prpi_checker
    import prpi_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [RANK_W-1:0] rank_value,
    input logic [ITER_W-1:0] iterations_done,
    input logic              converged,
    input logic              last
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rank_value) && $stable(last))
        else $error("stalled result changed");

    // ranks are normalized to at most one
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rank_value <= ONE_Q31)
        else $error("rank above one");

    // no new item is taken while a run still has pages to emit
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !last |-> !req_ready)
        else $error("request taken during emit");

    // convergence needs at least one iteration
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && converged |-> iterations_done != '0)
        else $error("converged without iterations");

endmodule

bind pagerank_power_iteration_top prpi_checker u_prpi_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rank_value      (rsp.rank_value),
    .iterations_done (rsp.iterations_done),
    .converged       (rsp.converged),
    .last            (rsp.last)
);
